/* hw/rtl/rht_pkg.sv */
// ----------------------------------------------------------------------------
// rht_pkg: shared types and constants for the reference-counted handle table
// Request and response structs, operation and status codes, and the fixed
// field widths of handles, counts and generations.
// ----------------------------------------------------------------------------
package rht_pkg;

  localparam int KEY_W      = 64;
  localparam int RES_IN_W   = 32;
  localparam int HANDLE_W   = 24;
  localparam int SLOT_W     = 16;
  localparam int GEN_W      = 8;
  localparam int COUNT_W    = 16;
  localparam int STATUS_W   = 3;
  localparam int KIND_W     = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESOLVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOAD_FAIL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREED      = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic                load_ok;
    logic [RES_IN_W-1:0] loaded_resource;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [RES_IN_W-1:0] resource_out;
    logic [COUNT_W-1:0]  ref_count;
  } rsp_t;

  // Write enables of the two slot memories.
  typedef struct packed {
    logic meta_we;
    logic res_we;
  } wr_en_t;

endpackage

/* hw/rtl/refcounted_handle_table.sv */
// ----------------------------------------------------------------------------
// refcounted_handle_table: keyed slot table with reference counts
// Acquire, release, resolve and count query on handles that carry a slot
// number and a per-slot generation, so stale handles are rejected.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                      Carries
//   -------   --------------------------   ---------------------------------
//   cmd       cmd_valid, cmd_stall, cmd    one request (kind, key, handle,
//                                          load_ok, loaded_resource)
//   rsp       rsp_valid, rsp_stall, rsp    one response per request (status,
//                                          handle_out, resource_out, ref_count)
//
// An acquire runs a slot scan before its response: the scan reads one
// metadata entry per cycle through the single read port of the metadata
// memory and always covers the whole table. Release, resolve and count
// query read the slot named by the handle, check it and, for a release,
// write back. After reset the block clears every metadata entry, one entry
// per cycle, with cmd_stall high throughout.
// A pending response waits in the output register while rsp_stall is high;
// the next request is still accepted and runs up to its completion, where it
// waits for the register to be free.
//
// The block works on one request at a time. Each slot keeps its count,
// generation and key together in one metadata word, and its resource word in
// a second memory. The scan records the lowest live slot with a matching key
// and the lowest free slot; a hit bumps the count (saturating), otherwise a
// free slot is loaded if one was found and the load succeeded. Handle checks read the slot named by the handle and
// compare its generation; a release that drops the count to zero advances the
// generation and hands back the resource word to be freed.
//
module refcounted_handle_table import rht_pkg::*; #(
  parameter int ENTRIES       = 128,
  parameter int KEY_BITS      = 64,
  parameter int RESOURCE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Only the low RES_W bits (at most 32) of the loader word reach the table.
  localparam int RES_W  = (RESOURCE_BITS < RES_IN_W) ? RESOURCE_BITS : RES_IN_W;
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int META_W = COUNT_W + GEN_W + KEY_BITS;

  wr_en_t            wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [META_W-1:0] wr_meta;
  logic [RES_W-1:0]  wr_res;
  logic [IDX_W-1:0]  rd_addr;
  logic [META_W-1:0] rd_meta;
  logic [RES_W-1:0]  rd_res;

  // Sequencer: scan, handle check, write-back and the response register.
  rht_ctrl #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .RES_W    (RES_W),
    .IDX_W    (IDX_W),
    .META_W   (META_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .rd_addr   (rd_addr),
    .rd_meta   (rd_meta),
    .rd_res    (rd_res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_meta   (wr_meta),
    .wr_res    (wr_res)
  );

  // Slot memories with registered read data.
  rht_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .RES_W    (RES_W),
    .IDX_W    (IDX_W),
    .META_W   (META_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_meta (wr_meta),
    .wr_res  (wr_res),
    .rd_addr (rd_addr),
    .rd_meta (rd_meta),
    .rd_res  (rd_res)
  );

endmodule

/* hw/rtl/rht_store.sv */
// ----------------------------------------------------------------------------
// rht_store: slot memories
// Metadata memory (count, generation, key) and resource memory, each with one
// write port and one read port whose data is registered.
// ----------------------------------------------------------------------------
module rht_store import rht_pkg::*; #(
  parameter int ENTRIES  = 128,
  parameter int KEY_BITS = 64,
  parameter int RES_W    = 32,
  parameter int IDX_W    = 7,
  parameter int META_W   = COUNT_W + GEN_W + KEY_BITS
) (
  input  logic              clk,
  input  wr_en_t            wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [META_W-1:0] wr_meta,
  input  logic [RES_W-1:0]  wr_res,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [META_W-1:0] rd_meta,
  output logic [RES_W-1:0]  rd_res
);

  logic [META_W-1:0] meta_mem [ENTRIES];
  logic [RES_W-1:0]  res_mem  [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en.meta_we) begin
      meta_mem[wr_addr] <= wr_meta;
    end
    rd_meta <= meta_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en.res_we) begin
      res_mem[wr_addr] <= wr_res;
    end
    rd_res <= res_mem[rd_addr];
  end

endmodule

/* hw/rtl/rht_ctrl.sv */
// ----------------------------------------------------------------------------
// rht_ctrl: request sequencer
// Clears the metadata after reset, scans the slots for acquires, checks
// handles for the other requests, writes back and holds the response register.
// ----------------------------------------------------------------------------
module rht_ctrl import rht_pkg::*; #(
  parameter int ENTRIES  = 128,
  parameter int KEY_BITS = 64,
  parameter int RES_W    = 32,
  parameter int IDX_W    = 7,
  parameter int META_W   = COUNT_W + GEN_W + KEY_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_t              cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  output logic [IDX_W-1:0]  rd_addr,
  input  logic [META_W-1:0] rd_meta,
  input  logic [RES_W-1:0]  rd_res,
  output wr_en_t            wr_en,
  output logic [IDX_W-1:0]  wr_addr,
  output logic [META_W-1:0] wr_meta,
  output logic [RES_W-1:0]  wr_res
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_WAIT, S_CHECK, S_DONE
  } state_t;

  state_t                state;
  logic [IDX_W-1:0]      addr;
  logic                  issuing;
  logic                  pend_v;
  logic [IDX_W-1:0]      pend_idx;
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [COUNT_W-1:0]    hit_count;
  logic [GEN_W-1:0]      hit_gen;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [GEN_W-1:0]      free_gen;
  logic [KIND_W-1:0]     op_kind;
  logic [KEY_BITS-1:0]   op_key;
  logic [GEN_W-1:0]      op_gen;
  logic                  op_load_ok;
  logic [RES_W-1:0]      op_res;
  logic                  range_ok;
  rsp_t                  result;
  rsp_t                  result_next;

  logic [SLOT_W-1:0]     cmd_slot;
  logic [SLOT_W-1:0]     cmd_slot_m1;
  logic                  cmd_range_ok;
  logic [COUNT_W-1:0]    m_count;
  logic [GEN_W-1:0]      m_gen;
  logic [KEY_BITS-1:0]   m_key;
  logic                  m_live;
  logic                  m_match;
  logic                  handle_ok;
  logic [COUNT_W-1:0]    dec_count;
  logic [COUNT_W-1:0]    inc_count;

  assign cmd_slot     = cmd.handle[SLOT_W-1:0];
  assign cmd_slot_m1  = cmd_slot - SLOT_W'(1);
  assign cmd_range_ok = (cmd_slot != '0) && (32'(cmd_slot_m1) < 32'(ENTRIES));

  assign m_count = rd_meta[META_W-1 -: COUNT_W];
  assign m_gen   = rd_meta[KEY_BITS +: GEN_W];
  assign m_key   = rd_meta[KEY_BITS-1:0];
  assign m_live  = (m_count != '0);
  assign m_match = m_live && (m_key == op_key);

  assign handle_ok = range_ok && (m_gen == op_gen) &&
                     ((op_kind == KIND_QUERY) || m_live);
  assign dec_count = m_count - COUNT_W'(1);
  assign inc_count = (hit_count == COUNT_MAX) ? COUNT_MAX : hit_count + COUNT_W'(1);

  assign cmd_stall = (state != S_IDLE);
  assign rd_addr   = addr;

  always_comb begin
    result_next = '0;
    wr_en       = '0;
    wr_addr     = addr;
    wr_meta     = '0;
    wr_res      = op_res;
    case (state)
      S_CLEAR: begin
        wr_en.meta_we = 1'b1;
      end
      S_DECIDE: begin
        if (hit_found) begin
          wr_en.meta_we          = 1'b1;
          wr_addr                = hit_idx;
          wr_meta                = {inc_count, hit_gen, op_key};
          result_next.handle_out = {hit_gen, SLOT_W'(hit_idx) + SLOT_W'(1)};
          result_next.ref_count  = inc_count;
        end else if (!free_found) begin
          result_next.status = ST_FULL;
        end else if (!op_load_ok) begin
          result_next.status = ST_LOAD_FAIL;
        end else begin
          wr_en.meta_we          = 1'b1;
          wr_en.res_we           = 1'b1;
          wr_addr                = free_idx;
          wr_meta                = {COUNT_W'(1), free_gen, op_key};
          result_next.handle_out = {free_gen, SLOT_W'(free_idx) + SLOT_W'(1)};
          result_next.ref_count  = COUNT_W'(1);
        end
      end
      S_CHECK: begin
        if (!handle_ok) begin
          result_next.status = ST_BAD_HANDLE;
        end else begin
          case (op_kind)
            KIND_RELEASE: begin
              wr_en.meta_we         = 1'b1;
              result_next.ref_count = dec_count;
              if (dec_count == '0) begin
                wr_meta                  = {dec_count, m_gen + GEN_W'(1), m_key};
                result_next.status       = ST_FREED;
                result_next.resource_out = RES_IN_W'(rd_res);
              end else begin
                wr_meta = {dec_count, m_gen, m_key};
              end
            end
            KIND_RESOLVE: begin
              result_next.resource_out = RES_IN_W'(rd_res);
              result_next.ref_count    = m_count;
            end
            KIND_QUERY: begin
              result_next.ref_count = m_count;
            end
            default: begin
              result_next.status = ST_BAD_HANDLE;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      addr       <= '0;
      issuing    <= 1'b0;
      pend_v     <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      // The completion state reloads the register itself in this case.
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (addr == LAST) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            op_kind    <= cmd.kind;
            op_key     <= cmd.key[KEY_BITS-1:0];
            op_gen     <= cmd.handle[SLOT_W +: GEN_W];
            op_load_ok <= cmd.load_ok;
            op_res     <= cmd.loaded_resource[RES_W-1:0];
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            pend_v     <= 1'b0;
            if (cmd.kind == KIND_ACQUIRE) begin
              addr    <= '0;
              issuing <= 1'b1;
              state   <= S_SCAN;
            end else begin
              addr     <= cmd_range_ok ? cmd_slot_m1[IDX_W-1:0] : '0;
              range_ok <= cmd_range_ok;
              state    <= S_WAIT;
            end
          end
        end
        S_SCAN: begin
          pend_v   <= issuing;
          pend_idx <= addr;
          if (issuing) begin
            if (addr == LAST) begin
              issuing <= 1'b0;
            end else begin
              addr <= addr + IDX_W'(1);
            end
          end
          if (pend_v) begin
            if (!hit_found && m_match) begin
              hit_found <= 1'b1;
              hit_idx   <= pend_idx;
              hit_count <= m_count;
              hit_gen   <= m_gen;
            end
            if (!free_found && !m_live) begin
              free_found <= 1'b1;
              free_idx   <= pend_idx;
              free_gen   <= m_gen;
            end
            if (!issuing) begin
              state <= S_DECIDE;
            end
          end
        end
        S_WAIT: begin
          state <= S_CHECK;
        end
        S_DECIDE, S_CHECK: begin
          result <= result_next;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp       <= result;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A request is taken only when nothing else is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("request accepted while another was in flight");

  // A response appears only out of the completion state.
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("response raised outside completion");

  // The memories are never written while waiting for a request.
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!wr_en.meta_we && !wr_en.res_we))
    else $error("slot memory written while idle");

  // A freed slot always reports a count of zero.
  a_freed_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.status != ST_FREED) || (rsp.ref_count == '0)))
    else $error("freed slot with nonzero count");

  // Only a successful acquire returns a handle.
  a_handle_only_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.handle_out == '0))
    else $error("handle returned with failing status");

endmodule
